### src/tab_separated_record_parser_core_assert.svh
// Assertion macros used by the top level of the tab-separated record parser.
`ifndef TAB_SEPARATED_RECORD_PARSER_CORE_ASSERT_SVH
`define TAB_SEPARATED_RECORD_PARSER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TSRP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tsrp_pkg.sv
// Shared types and constants of the tab-separated record parser.
package tsrp_pkg;

  localparam int BYTE_W     = 8;
  localparam int ID_W       = 32;
  localparam int OUT_W      = 32;
  localparam int DATA_W     = 6 * OUT_W;
  localparam int CFG_IDX_W  = 1;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SEP_RESET  = 8'd9;
  localparam logic [BYTE_W-1:0] TERM_RESET = 8'd10;
  localparam logic [ID_W-1:0]   ZERO_CHAR  = 32'd48;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SEP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_END = 1'b1;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] PUSH_NONE = 2'd0;
  localparam logic [1:0] PUSH_ONE  = 2'd1;
  localparam logic [1:0] PUSH_TWO  = 2'd2;

  typedef enum logic [2:0] {
    PH_ID,
    PH_LANG_START,
    PH_LANG_BODY,
    PH_TEXT_START,
    PH_TEXT_BODY
  } phase_t;

  typedef struct packed {
    logic             result_kind;
    logic [OUT_W-1:0] record_id;
    logic [OUT_W-1:0] lang_start;
    logic [OUT_W-1:0] lang_end;
    logic [OUT_W-1:0] text_start;
    logic [OUT_W-1:0] text_end;
    logic [OUT_W-1:0] records_seen;
    logic             last_result;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  typedef struct packed {
    logic             ready;
    logic [CNT_W-1:0] count;
  } fifo_status_t;

endpackage

### src/tsrp_parser.sv
// Byte-level parse state machine and field position capture.
module tsrp_parser #(
  parameter int POSITION_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsrp_pkg::BYTE_W-1:0]        cfg_data,
  input  logic                               in_accept,
  input  logic [tsrp_pkg::BYTE_W-1:0]        in_byte,
  input  logic                               in_last,
  output tsrp_pkg::push_t                    push
);
  import tsrp_pkg::*;

  logic [BYTE_W-1:0]        field_sep;
  logic [BYTE_W-1:0]        record_end;
  phase_t                   phase;
  phase_t                   phase_next;
  logic [ID_W-1:0]          id_acc;
  logic [ID_W-1:0]          id_acc_next;
  logic [POSITION_BITS-1:0] lang_start_pos;
  logic [POSITION_BITS-1:0] lang_start_pos_next;
  logic [POSITION_BITS-1:0] lang_end_pos;
  logic [POSITION_BITS-1:0] lang_end_pos_next;
  logic [POSITION_BITS-1:0] text_start_pos;
  logic [POSITION_BITS-1:0] text_start_pos_next;
  logic [POSITION_BITS-1:0] byte_pos;
  logic [POSITION_BITS-1:0] byte_pos_next;
  logic [OUT_W-1:0]         rec_count;
  logic [OUT_W-1:0]         rec_count_next;

  logic            is_sep;
  logic            is_term;
  logic            rec_done;
  logic [ID_W-1:0] byte_signed;
  result_t         rec_result;
  result_t         sum_result;

  function automatic logic [OUT_W-1:0] to_out(input logic [POSITION_BITS-1:0] p);
    logic [POSITION_BITS+OUT_W-1:0] wide;
    wide = {{OUT_W{1'b0}}, p};
    return wide[OUT_W-1:0];
  endfunction

  assign is_sep   = (in_byte == field_sep);
  assign is_term  = (in_byte == record_end);
  assign rec_done = (phase == PH_TEXT_BODY) && is_term;
  assign byte_signed = {{(ID_W-BYTE_W){in_byte[BYTE_W-1]}}, in_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      field_sep  <= SEP_RESET;
      record_end <= TERM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIELD_SEP:  field_sep  <= cfg_data;
        REG_RECORD_END: record_end <= cfg_data;
        default: ;
      endcase
    end
  end

  // Phase transitions.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_LANG_START: phase_next = PH_LANG_BODY;
      PH_LANG_BODY:  if (is_sep) phase_next = PH_TEXT_START;
      PH_TEXT_START: phase_next = PH_TEXT_BODY;
      PH_TEXT_BODY:  if (is_term) phase_next = PH_ID;
      default:       phase_next = is_sep ? PH_LANG_START : PH_ID;
    endcase
    if (in_last) begin
      phase_next = PH_ID;
    end
  end

  // Datapath updates and result formation.
  always_comb begin
    id_acc_next         = id_acc;
    lang_start_pos_next = lang_start_pos;
    lang_end_pos_next   = lang_end_pos;
    text_start_pos_next = text_start_pos;
    byte_pos_next       = byte_pos + POSITION_BITS'(1);
    rec_count_next      = rec_count;

    unique case (phase)
      PH_LANG_START: lang_start_pos_next = byte_pos;
      PH_LANG_BODY:  if (is_sep) lang_end_pos_next = byte_pos;
      PH_TEXT_START: text_start_pos_next = byte_pos;
      PH_TEXT_BODY: begin
        if (is_term) begin
          rec_count_next = rec_count + OUT_W'(1);
          id_acc_next    = '0;
        end
      end
      default: begin
        // Any non-separator byte is folded in as a digit, unchecked.
        if (!is_sep) begin
          id_acc_next = (id_acc << 3) + (id_acc << 1) + byte_signed - ZERO_CHAR;
        end
      end
    endcase

    rec_result.result_kind  = KIND_RECORD;
    rec_result.record_id    = id_acc;
    rec_result.lang_start   = to_out(lang_start_pos);
    rec_result.lang_end     = to_out(lang_end_pos);
    rec_result.text_start   = to_out(text_start_pos);
    rec_result.text_end     = to_out(byte_pos);
    rec_result.records_seen = rec_count_next;
    rec_result.last_result  = !in_last;

    sum_result              = '0;
    sum_result.result_kind  = KIND_SUMMARY;
    sum_result.records_seen = rec_count_next;
    sum_result.last_result  = 1'b1;

    if (in_last) begin
      id_acc_next         = '0;
      lang_start_pos_next = '0;
      lang_end_pos_next   = '0;
      text_start_pos_next = '0;
      byte_pos_next       = '0;
      rec_count_next      = '0;
    end

    push.second = sum_result;
    if (rec_done) begin
      push.first = rec_result;
      push.count = in_last ? PUSH_TWO : PUSH_ONE;
    end else begin
      push.first = sum_result;
      push.count = in_last ? PUSH_ONE : PUSH_NONE;
    end
    if (!in_accept) begin
      push.count = PUSH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_ID;
      id_acc         <= '0;
      lang_start_pos <= '0;
      lang_end_pos   <= '0;
      text_start_pos <= '0;
      byte_pos       <= '0;
      rec_count      <= '0;
    end else if (in_accept) begin
      phase          <= phase_next;
      id_acc         <= id_acc_next;
      lang_start_pos <= lang_start_pos_next;
      lang_end_pos   <= lang_end_pos_next;
      text_start_pos <= text_start_pos_next;
      byte_pos       <= byte_pos_next;
      rec_count      <= rec_count_next;
    end
  end

endmodule

### src/tsrp_result_fifo.sv
// Small result queue: up to two results in per cycle, one out on pop_ready.
module tsrp_result_fifo (
  input  logic                   clk,
  input  logic                   rst,
  input  tsrp_pkg::push_t        push,
  input  logic                   pop_ready,
  output logic                   head_valid,
  output tsrp_pkg::result_t      head,
  output tsrp_pkg::fifo_status_t status
);
  import tsrp_pkg::*;

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;

  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign pop        = head_valid && pop_ready;

  // Room for a full pair of results keeps the input side open.
  assign status.ready = (count <= CNT_W'(FIFO_DEPTH - 2));
  assign status.count = count;

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.count);
    rd_ptr_next = rd_ptr + PTR_W'(pop);
    count_next  = count + CNT_W'(push.count) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != PUSH_NONE) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == PUSH_TWO) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

### src/tab_separated_record_parser_core.sv
// Top level of the tab-separated record parser.
//
// The parser takes one byte per clock cycle while s_tready is high and updates
// its phase, id accumulator and field positions in the same cycle that the
// byte is accepted. Each completed record and each end-of-buffer summary
// leaves as one output transaction through a four-entry result queue. A
// result is presented at the earliest in the cycle after the byte that caused
// it. A byte that both ends a record and carries the last-byte mark yields
// two results; the queue drains one result per cycle while m_tready is high,
// so the summary of such a pair follows the record result. The sustained rate
// is one byte per cycle as long as results are taken at the rate they are
// produced. The input is ready whenever the queue has room for two results.
// Delimiters may only be rewritten while the block is idle.
module tab_separated_record_parser_core #(
  parameter int POSITION_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tsrp_pkg::BYTE_W-1:0]        s_tdata,   // stream_byte
  input  logic                               s_tlast,   // last_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // record_id, lang_start, lang_end, text_start, text_end, records_seen
  output logic [tsrp_pkg::DATA_W-1:0]        m_tdata,
  output logic                               m_tuser,   // result_kind
  output logic                               m_tlast,   // last_result
  input  logic                               cfg_we,
  input  logic [tsrp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tsrp_pkg::BYTE_W-1:0]        cfg_data
);
  import tsrp_pkg::*;

  `include "tab_separated_record_parser_core_assert.svh"

  push_t        push;
  result_t      head;
  fifo_status_t fifo_status;
  logic         in_accept;

  assign s_tready  = fifo_status.ready;
  assign in_accept = s_tvalid && s_tready;

  tsrp_parser #(
    .POSITION_BITS(POSITION_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .push      (push)
  );

  tsrp_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .pop_ready  (m_tready),
    .head_valid (m_tvalid),
    .head       (head),
    .status     (fifo_status)
  );

  assign m_tdata = {head.records_seen, head.text_end, head.text_start,
                    head.lang_end, head.lang_start, head.record_id};
  assign m_tuser = head.result_kind;
  assign m_tlast = head.last_result;

  `TSRP_ASSERT_SAME(a_fifo_bound, 1'b1, fifo_status.count <= CNT_W'(FIFO_DEPTH), "result queue overflow")
  `TSRP_ASSERT_NEXT(a_summary_follows, in_accept && s_tlast, m_tvalid, "no summary after last byte")
  `TSRP_ASSERT_SAME(a_summary_last, m_tvalid && m_tuser, m_tlast, "summary not marked last")
  `TSRP_ASSERT_SAME(a_summary_zero_id, m_tvalid && m_tuser, m_tdata[OUT_W-1:0] == '0, "summary id not zero")

endmodule

### bench/tb_tab_separated_record_parser_core.sv
// Self-checking bench for the tab-separated record parser core with random stream and stalls.
module tb_tab_separated_record_parser_core;
  import tsrp_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_ITEMS = 50;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [BYTE_W-1:0] s_tdata;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [DATA_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0] cfg_data;

  // Parser mirror: delimiters, phase, id and field positions.
  logic [7:0] sep_char;
  logic [7:0] term_char;
  phase_t cur_phase;
  logic [31:0] id_sum;
  logic [31:0] lang_first;
  logic [31:0] lang_stop;
  logic [31:0] text_first;
  logic [31:0] next_pos;
  logic [31:0] record_total;

  result_t expected_results[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int stall_left = 0;
  bit src_idle = 1'b1;
  bit sink_idle = 1'b1;

  tab_separated_record_parser_core u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void clear_parser();
    cur_phase = PH_ID;
    id_sum = '0;
    lang_first = '0;
    lang_stop = '0;
    text_first = '0;
    next_pos = '0;
    record_total = '0;
  endfunction

  function automatic void push_result(logic kind, logic [31:0] id, logic [31:0] ls,
                                      logic [31:0] le, logic [31:0] ts, logic [31:0] te,
                                      logic [31:0] seen, logic final_one);
    result_t r;
    r.result_kind = kind;
    r.record_id = id;
    r.lang_start = ls;
    r.lang_end = le;
    r.text_start = ts;
    r.text_end = te;
    r.records_seen = seen;
    r.last_result = final_one;
    expected_results.push_back(r);
  endfunction

  function automatic void parse_byte(logic [7:0] data, logic mark_last);
    logic [31:0] pos;
    logic [31:0] widened;
    pos = next_pos;
    case (cur_phase)
      PH_LANG_START: begin
        lang_first = pos;
        cur_phase = PH_LANG_BODY;
      end
      PH_LANG_BODY: begin
        if (data == sep_char) begin
          lang_stop = pos;
          cur_phase = PH_TEXT_START;
        end
      end
      PH_TEXT_START: begin
        text_first = pos;
        cur_phase = PH_TEXT_BODY;
      end
      PH_TEXT_BODY: begin
        if (data == term_char) begin
          record_total = record_total + 32'd1;
          push_result(KIND_RECORD, id_sum, lang_first, lang_stop, text_first, pos,
                      record_total, !mark_last);
          id_sum = '0;
          cur_phase = PH_ID;
        end
      end
      default: begin
        if (data == sep_char) begin
          cur_phase = PH_LANG_START;
        end else begin
          // The byte is sign-extended before the ASCII zero is taken off.
          widened = {{24{data[7]}}, data};
          id_sum = id_sum * 32'd10 + widened - ZERO_CHAR;
          cur_phase = PH_ID;
        end
      end
    endcase
    next_pos = pos + 32'd1;
    if (mark_last) begin
      push_result(KIND_SUMMARY, '0, '0, '0, '0, '0, record_total, 1'b1);
      clear_parser();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("cycle %0d: %s got %h, want %h", cycle_count, what, got, want);
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result, record_id", m_tdata[OUT_W-1:0], '0);
    end else begin
      want = expected_results.pop_front();
      compare_field("result_kind", 32'(m_tuser), 32'(want.result_kind));
      compare_field("record_id", m_tdata[0*OUT_W +: OUT_W], want.record_id);
      compare_field("lang_start", m_tdata[1*OUT_W +: OUT_W], want.lang_start);
      compare_field("lang_end", m_tdata[2*OUT_W +: OUT_W], want.lang_end);
      compare_field("text_start", m_tdata[3*OUT_W +: OUT_W], want.text_start);
      compare_field("text_end", m_tdata[4*OUT_W +: OUT_W], want.text_end);
      compare_field("records_seen", m_tdata[5*OUT_W +: OUT_W], want.records_seen);
      compare_field("last_result", 32'(m_tlast), 32'(want.last_result));
    end
  endtask

  // One process sees every transaction, so the order of events at an edge does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
      if (cfg_we) begin
        if (cfg_index == REG_FIELD_SEP) sep_char = cfg_data;
        else if (cfg_index == REG_RECORD_END) term_char = cfg_data;
      end
    end
  end

  always @(negedge clk) begin
    if (sink_idle && stall_left == 0 && $urandom_range(0, 4) == 0)
      stall_left = $urandom_range(1, 11);
    if (sink_idle && stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic mark_last);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= data;
    s_tlast <= mark_last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_delimiters(input logic [7:0] sep_value, input logic [7:0] term_value);
    cfg_we <= 1'b1;
    cfg_index <= REG_FIELD_SEP;
    cfg_data <= sep_value;
    @(negedge clk);
    cfg_index <= REG_RECORD_END;
    cfg_data <= term_value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] byte_except(logic [7:0] avoid);
    logic [7:0] r;
    do r = 8'($urandom_range(0, 255)); while (r == avoid);
    return r;
  endfunction

  function automatic logic [7:0] digit_except(logic [7:0] avoid);
    logic [7:0] r;
    do r = 8'h30 + 8'($urandom_range(0, 9)); while (r == avoid);
    return r;
  endfunction

  // Appends one record; language and text may open with any byte, delimiters included.
  function automatic void build_record(ref logic [7:0] q[$]);
    int digits;
    int lang_len;
    int text_len;
    digits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : $urandom_range(1, 6);
    lang_len = $urandom_range(1, 6);
    text_len = $urandom_range(1, 12);
    for (int i = 0; i < digits; i++)
      q.push_back(($urandom_range(0, 9) == 0) ? byte_except(sep_char) : digit_except(sep_char));
    q.push_back(sep_char);
    q.push_back(($urandom_range(0, 4) == 0) ? sep_char : 8'($urandom_range(0, 255)));
    for (int i = 1; i < lang_len; i++) q.push_back(byte_except(sep_char));
    q.push_back(sep_char);
    q.push_back(($urandom_range(0, 4) == 0) ? term_char : 8'($urandom_range(0, 255)));
    for (int i = 1; i < text_len; i++) q.push_back(byte_except(term_char));
    q.push_back(term_char);
  endfunction

  // A buffer of whole records that ends on a terminator, an extra byte or a cut record.
  task automatic send_buffer();
    logic [7:0] q[$];
    int stop_at;
    int ending;
    repeat ($urandom_range(1, 5)) build_record(q);
    ending = $urandom_range(0, 9);
    if (ending < 5) begin
      stop_at = q.size() - 1;
    end else if (ending < 8) begin
      q.push_back(8'($urandom_range(0, 255)));
      stop_at = q.size() - 1;
    end else begin
      stop_at = $urandom_range(0, q.size() - 2);
    end
    for (int i = 0; i <= stop_at; i++) send_byte(q[i], i == stop_at);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  task automatic test_field_starts();
    send_byte(SEP_RESET, 1'b0);   // empty id
    send_byte(SEP_RESET, 1'b0);   // separator opens the language field
    send_byte("a", 1'b0);
    send_byte(SEP_RESET, 1'b0);
    send_byte(TERM_RESET, 1'b0);  // terminator opens the text field
    send_byte("z", 1'b0);
    send_byte(TERM_RESET, 1'b1);  // record and summary from one byte
    wait_idle();
  endtask

  task automatic test_id_extremes();
    send_byte(TERM_RESET, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(SEP_RESET, 1'b0);
    send_byte("x", 1'b0);
    send_byte(TERM_RESET, 1'b0);  // terminator inside the language field
    send_byte(SEP_RESET, 1'b0);
    send_byte("y", 1'b0);
    send_byte(TERM_RESET, 1'b0);
    wait_idle();
  endtask

  task automatic test_partial_record();
    send_byte("1", 1'b0);
    send_byte(SEP_RESET, 1'b0);
    send_byte("q", 1'b1);
    wait_idle();
  endtask

  task automatic test_delimiter_settings();
    logic [7:0] seps[6] = '{8'h00, 8'hFF, 8'h2C, 8'h35, 8'h00, 8'h09};
    logic [7:0] terms[6] = '{8'hFF, 8'h00, 8'h2C, 8'h0A, 8'h00, 8'h0A};
    for (int i = 0; i < 6; i++) begin
      if (i == 4) begin
        seps[i] = 8'($urandom_range(0, 255));
        terms[i] = 8'($urandom_range(0, 255));
      end
      set_delimiters(seps[i], terms[i]);
      send_buffer();
      send_noise();
      wait_idle();
    end
  endtask

  task automatic test_random_stream();
    int goal;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 9) < 8) send_buffer();
      else send_noise();
    end
    wait_idle();
  endtask

  task automatic test_full_rate();
    int goal;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    goal = items_sent + CALM_ITEMS;
    while (items_sent < goal) send_buffer();
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_FIELD_SEP;
    cfg_data = '0;
    sep_char = SEP_RESET;
    term_char = TERM_RESET;
    clear_parser();
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_field_starts();
    test_id_extremes();
    test_partial_record();
    test_delimiter_settings();
    test_random_stream();
    test_full_rate();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
